@@ hdl/mpu_pkg.sv @@
// ----------------------------------------------------------------------------
// mpu_pkg: shared definitions for the modular power unit
// Field widths, stream packing offsets, command codes and the request
// struct that the sequencer hands to the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mpu_pkg;

	localparam int MOD_BITS_DEF = 31;
	localparam int EXP_BITS_DEF = 63;

	localparam int CMD_W  = 2;
	localparam int BASE_W = 63;
	localparam int EXPO_W = 63;
	localparam int MODU_W = 31;
	localparam int RES_W  = 64;

	localparam int BASE_LSB = 0;
	localparam int EXPO_LSB = BASE_LSB + BASE_W;
	localparam int MODU_LSB = EXPO_LSB + EXPO_W;
	localparam int S_DATA_W = ((BASE_W + EXPO_W + MODU_W + 7) / 8) * 8;

	localparam int CNT_W = $clog2(RES_W + 1);
	localparam int IDX_W = $clog2(RES_W);

	localparam logic [CMD_W-1:0] CMD_MODPOW = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INV    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POW    = 2'd2;

	typedef struct packed {
		logic             start;
		logic             modular;
		logic [CNT_W-1:0] nbits;
	} mul_req_t;

endpackage

`default_nettype wire

@@ hdl/mpu_mul.sv @@
// ----------------------------------------------------------------------------
// mpu_mul: bit-serial shift-add multiplier with optional modular reduction
// Walks the multiplier operand from its top bit down, one bit per cycle,
// doubling the partial result and adding the multiplicand. In modular mode
// each step is brought back below the modulus; otherwise it wraps to 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mpu_mul import mpu_pkg::*; #(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mul_req_t            req,
	input  wire logic [RES_W-1:0]    x,
	input  wire logic [RES_W-1:0]    y,
	input  wire logic [MOD_BITS-1:0] m,
	output logic                     done,
	output logic [RES_W-1:0]         prod
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             modular_q;
	logic [RES_W-1:0] x_q;
	logic [RES_W-1:0] y_q;
	logic [RES_W-1:0] r_q;

	logic [CNT_W-1:0] idx;
	logic             ybit;
	logic [RES_W-1:0] m_ext;
	logic [RES_W-1:0] dbl;
	logic [RES_W-1:0] dbl_red;
	logic [RES_W-1:0] sum;
	logic [RES_W-1:0] r_nxt;

	always_comb begin
		idx     = cnt_q - CNT_W'(1);
		ybit    = y_q[idx[IDX_W-1:0]];
		m_ext   = {{(RES_W - MOD_BITS){1'b0}}, m};
		dbl     = {r_q[RES_W-2:0], 1'b0};
		dbl_red = (modular_q && (dbl >= m_ext)) ? dbl - m_ext : dbl;
		sum     = dbl_red + (ybit ? x_q : '0);
		r_nxt   = (modular_q && (sum >= m_ext)) ? sum - m_ext : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= idx;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			modular_q <= req.modular;
			x_q       <= x;
			y_q       <= y;
			r_q       <= '0;
		end else if (busy_q) begin
			r_q <= r_nxt;
		end
	end

	assign done = done_q;
	assign prod = r_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiplier started while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("multiplier done while still busy");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && modular_q) |-> (r_q < m_ext))
		else $error("modular product not reduced");

endmodule

`default_nettype wire

@@ hdl/modular_power_unit.sv @@
// Modular power and inverse first reduce the base modulo the modulus, then handle each
// exponent bit with a multiply for a set bit and a square, all on the shared multiplier.
// Plain power skips the reduction and wraps each product to RES_W bits.
// Zero results (modulus below two, unknown command) skip the multiplier and go to S_DONE.
// One request is in work at a time; the bit-serial multiplier sets the pace.
// Reset is asynchronous and active low; it clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// modular_power_unit: square-and-multiply exponentiation engine
// A small sequencer runs right-to-left square-and-multiply, issuing every
// reduction, multiply and square to one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_power_unit import mpu_pkg::*; #(
	parameter int MOD_BITS = MOD_BITS_DEF,
	parameter int EXP_BITS = EXP_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // base, exponent, modulus, zero pad
	input  wire logic [CMD_W-1:0]    s_tuser,  // command
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [RES_W-1:0]         m_tdata   // result
);

	localparam int E_W = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_STEP = 6'b000010,
		S_RED  = 6'b000100,
		S_MUL  = 6'b001000,
		S_SQR  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic                start_q;
	logic                start_d;
	logic                m_tvalid_q;
	logic [RES_W-1:0]    m_tdata_q;
	logic                mod_mode_q;
	logic [RES_W-1:0]    acc_q;
	logic [RES_W-1:0]    b_q;
	logic [E_W-1:0]      e_q;
	logic [MOD_BITS-1:0] m_q;

	logic [BASE_W-1:0]   base_in;
	logic [EXPO_W-1:0]   expo_in;
	logic [MOD_BITS-1:0] m_in;
	logic                accept;
	logic                out_free;
	logic                m_big;
	logic                e_last;

	mul_req_t            mul_req;
	logic [RES_W-1:0]    mul_x;
	logic                mul_done;
	logic [RES_W-1:0]    mul_prod;

	assign base_in  = s_tdata[BASE_LSB +: BASE_W];
	assign expo_in  = s_tdata[EXPO_LSB +: EXPO_W];
	assign m_in     = s_tdata[MODU_LSB +: MOD_BITS];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_big    = (m_in >= MOD_BITS'(2));
	assign e_last   = (e_q[E_W-1:1] == '0);

	always_comb begin
		state_d = state_q;
		start_d = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == CMD_POW) begin
						state_d = S_STEP;
					end else if ((s_tuser == CMD_MODPOW || s_tuser == CMD_INV) && m_big) begin
						state_d = S_RED;
						start_d = 1'b1;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_STEP: begin
				if (e_q == '0) begin
					state_d = S_DONE;
				end else if (e_q[0]) begin
					state_d = S_MUL;
					start_d = 1'b1;
				end else begin
					state_d = S_SQR;
					start_d = 1'b1;
				end
			end
			S_RED, S_SQR: begin
				if (mul_done) begin
					state_d = S_STEP;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					if (e_last) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SQR;
						start_d = 1'b1;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					m_q        <= m_in;
					b_q        <= {1'b0, base_in};
					mod_mode_q <= (s_tuser != CMD_POW);
					if (s_tuser == CMD_INV) begin
						e_q <= E_W'(m_in - MOD_BITS'(2));
					end else begin
						e_q <= E_W'(expo_in[EXP_BITS-1:0]);
					end
					if (s_tuser == CMD_POW || ((s_tuser == CMD_MODPOW || s_tuser == CMD_INV)
							&& m_big)) begin
						acc_q <= RES_W'(1);
					end else begin
						acc_q <= '0;
					end
				end
			end
			S_STEP: begin
				if (e_q != '0 && !e_q[0]) begin
					e_q <= e_q >> 1;
				end
			end
			S_RED, S_SQR: begin
				if (mul_done) begin
					b_q <= mul_prod;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					acc_q <= mul_prod;
					e_q   <= e_q >> 1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mul_req.start   = start_q;
		mul_req.modular = mod_mode_q;
		if (state_q == S_RED) begin
			mul_req.nbits = CNT_W'(BASE_W);
		end else if (mod_mode_q) begin
			mul_req.nbits = CNT_W'(MOD_BITS);
		end else begin
			mul_req.nbits = CNT_W'(RES_W);
		end
		if (state_q == S_RED) begin
			mul_x = RES_W'(1);
		end else if (state_q == S_MUL) begin
			mul_x = acc_q;
		end else begin
			mul_x = b_q;
		end
	end

	mpu_mul #(
		.MOD_BITS(MOD_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.x      (mul_x),
		.y      (b_q),
		.m      (m_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_RED || state_q == S_MUL || state_q == S_SQR))
		else $error("multiplier result arrived outside an operation");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_STEP || state_q == S_RED || state_q == S_DONE))
		else $error("accepted request did not start work");

	a_step_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && e_q == '0) |=> (state_q == S_DONE))
		else $error("exhausted exponent did not finish");

endmodule

`default_nettype wire

@@ tb/modular_power_unit_tb.sv @@
// ----------------------------------------------------------------------------
// modular_power_unit_tb: self-checking bench for the modular power unit
// A table of directed requests covers the field extremes, every command and
// the corner cases: modulus zero or one, inverse modulo two, inverse of a
// multiple of the modulus, and the unused command. Random requests follow.
// Results are checked in order, against the row value where one is known and
// else a square-and-multiply model. Both sides idle randomly in 2 of 3 phases.
// ----------------------------------------------------------------------------
module modular_power_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpu_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int N_RANDOM = 117;
	localparam int END_CYCLES = 16;

	localparam logic [BASE_W-1:0] BASE_MAX = '1;
	localparam logic [EXPO_W-1:0] EXPO_MAX = '1;
	localparam logic [MODU_W-1:0] MODU_MAX = '1;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BASE_W-1:0] base;
		logic [EXPO_W-1:0] expo;
		logic [MODU_W-1:0] modu;
	} power_req_t;

	typedef struct {
		power_req_t       req;
		bit               known;
		logic [RES_W-1:0] want;
	} directed_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RES_W-1:0]    m_tdata;

	directed_row_t    directed_rows[$];
	logic [RES_W-1:0] pending_results[$];
	int               mismatch_count = 0;
	int               send_idle_pct = 33;
	int               recv_idle_pct = 77;

	modular_power_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] residue_power(logic [63:0] b, logic [63:0] e,
		logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1;
		if (m == 64'd0) begin
			return 64'd0;
		end
		b = b % m;
		while (e != 64'd0) begin
			if (e[0]) begin
				acc = (acc * b) % m;
			end
			e = e >> 1;
			b = (b * b) % m;
		end
		return acc % m;
	endfunction

	function automatic logic [63:0] wrapped_power(logic [63:0] b, logic [63:0] e);
		logic [63:0] acc;
		acc = 64'd1;
		while (e != 64'd0) begin
			if (e[0]) begin
				acc = acc * b;
			end
			e = e >> 1;
			b = b * b;
		end
		return acc;
	endfunction

	function automatic logic [RES_W-1:0] predict_result(power_req_t r);
		logic [RES_W-1:0] res;
		logic [63:0] m;
		m = 64'(r.modu);
		res = '0;
		case (r.cmd)
			CMD_MODPOW: begin
				res = residue_power(64'(r.base), 64'(r.expo), m);
			end
			CMD_INV: begin
				if (m >= 64'd2) begin
					res = residue_power(64'(r.base), m - 64'd2, m);
				end
			end
			CMD_POW: begin
				res = wrapped_power(64'(r.base), 64'(r.expo));
			end
			default: begin
				res = '0;
			end
		endcase
		return res;
	endfunction

	function automatic power_req_t random_request();
		power_req_t r;
		int unsigned pick;
		int unsigned width;
		logic [31:0] word;
		logic [63:0] wide;
		pick = $urandom_range(99);
		if (pick < 40) begin
			r.cmd = CMD_MODPOW;
		end else if (pick < 65) begin
			r.cmd = CMD_INV;
		end else if (pick < 95) begin
			r.cmd = CMD_POW;
		end else begin
			r.cmd = CMD_UNUSED;
		end

		pick = $urandom_range(99);
		if (pick < ((r.cmd == CMD_INV) ? 60 : 20)) begin
			case ($urandom_range(5))
				0: word = 32'd7;
				1: word = 32'd13;
				2: word = 32'd65537;
				3: word = 32'd1000003;
				4: word = 32'd998244353;
				default: word = 32'd2147483647;
			endcase
		end else if (pick < 60) begin
			word = $urandom_range(255, 2);
		end else if (pick < 92) begin
			word = $urandom;
		end else begin
			word = $urandom_range(2, 0);
		end
		r.modu = word[MODU_W-1:0];

		pick = $urandom_range(99);
		if (pick < 50) begin
			wide = {$urandom, $urandom};
		end else if (pick < 80) begin
			wide = 64'($urandom_range(1000, 0));
		end else if (pick < 90) begin
			wide = 64'(r.modu) * 64'($urandom_range(1000, 0));
		end else if (pick < 95) begin
			wide = '1;
		end else begin
			wide = 64'($urandom_range(1, 0));
		end
		r.base = wide[BASE_W-1:0];

		pick = $urandom_range(99);
		if (pick < 80) begin
			width = $urandom_range(12, 0);
		end else if (pick < 95) begin
			width = $urandom_range(32, 13);
		end else begin
			width = EXPO_W;
		end
		wide = {$urandom, $urandom} & ((64'd1 << width) - 64'd1);
		r.expo = wide[EXPO_W-1:0];
		return r;
	endfunction

	task automatic add_row(logic [CMD_W-1:0] cmd, logic [BASE_W-1:0] base,
		logic [EXPO_W-1:0] expo, logic [MODU_W-1:0] modu, bit known,
		logic [RES_W-1:0] want);
		directed_row_t row;
		row.req.cmd = cmd;
		row.req.base = base;
		row.req.expo = expo;
		row.req.modu = modu;
		row.known = known;
		row.want = want;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic report_mismatch(string what, logic [RES_W-1:0] got,
		logic [RES_W-1:0] want);
		$display("tb: %s at %0t ns: got %h, expected %h", what, $time, got, want);
		mismatch_count++;
	endtask

	task automatic drive_request(power_req_t r, int idle_pct);
		int gap;
		logic [S_DATA_W-1:0] packed_data;
		gap = 0;
		while ($urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		packed_data = '0;
		packed_data[BASE_LSB +: BASE_W] = r.base;
		packed_data[EXPO_LSB +: EXPO_W] = r.expo;
		packed_data[MODU_LSB +: MODU_W] = r.modu;
		s_tvalid <= 1'b1;
		s_tdata <= packed_data;
		s_tuser <= r.cmd;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", m_tdata, '0);
			end else if (m_tdata !== pending_results[0]) begin
				report_mismatch("result mismatch", m_tdata, pending_results.pop_front());
			end else begin
				void'(pending_results.pop_front());
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		power_req_t r;
		logic [RES_W-1:0] want;
		int total;
		int idx;
		int phase;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_MODPOW;

		add_row(CMD_MODPOW, 0, 0, 1, 1, 0);
		add_row(CMD_MODPOW, 5, 0, 7, 1, 1);
		add_row(CMD_MODPOW, 2, 10, 1000, 1, 24);
		add_row(CMD_MODPOW, 9, 3, 0, 1, 0);
		add_row(CMD_MODPOW, 0, 5, 13, 1, 0);
		add_row(CMD_MODPOW, 1, EXPO_MAX, 2, 1, 1);
		add_row(CMD_MODPOW, BASE_MAX, EXPO_MAX, MODU_MAX, 0, 0);
		add_row(CMD_MODPOW, 12345, 65537, 1000003, 0, 0);
		add_row(CMD_INV, 5, 3, 1, 1, 0);
		add_row(CMD_INV, 5, 3, 0, 1, 0);
		add_row(CMD_INV, 1, EXPO_MAX, 2, 1, 1);
		add_row(CMD_INV, 14, 9, 7, 1, 0);
		add_row(CMD_INV, 3, 0, 7, 0, 0);
		add_row(CMD_INV, BASE_MAX, EXPO_MAX, MODU_MAX, 0, 0);
		add_row(CMD_POW, 0, 0, 0, 1, 1);
		add_row(CMD_POW, 0, 1, 5, 1, 0);
		add_row(CMD_POW, 2, 63, MODU_MAX, 1, 64'h8000_0000_0000_0000);
		add_row(CMD_POW, 2, 64, 3, 1, 0);
		add_row(CMD_POW, BASE_MAX, 1, 0, 1, 64'(BASE_MAX));
		add_row(CMD_POW, BASE_MAX, 2, 1, 0, 0);
		add_row(CMD_POW, BASE_MAX, EXPO_MAX, MODU_MAX, 0, 0);
		add_row(CMD_UNUSED, BASE_MAX, EXPO_MAX, MODU_MAX, 1, 0);
		add_row(CMD_UNUSED, 0, 0, 0, 1, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total = directed_rows.size() + N_RANDOM;
		for (idx = 0; idx < total; idx++) begin
			phase = (idx * 3) / total;
			send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 77 : 0;
			recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 33 : 0;
			if (idx < directed_rows.size()) begin
				r = directed_rows[idx].req;
				want = directed_rows[idx].known ? directed_rows[idx].want : predict_result(r);
			end else begin
				r = random_request();
				want = predict_result(r);
			end
			drive_request(r, send_idle_pct);
			pending_results.insert(pending_results.size(), want);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/mpu_pkg.sv
hdl/mpu_mul.sv
hdl/modular_power_unit.sv
tb/modular_power_unit_tb.sv
